@@ design/tmg_pkg.sv @@
// Shared types, constants and the gamma table builder for the tonemap/gamma block.
// No dependencies; used by tmg_ratio, tmg_gamma and aces_tonemap_gamma_encode.
package tmg_pkg;

  localparam int INPUT_WIDTH       = 24;
  localparam int OUTPUT_WIDTH      = 16;
  localparam int GAMMA_TABLE_DEPTH = 1024;

  // Fraction bits of the tone mapped ratio and of the gamma table entries.
  localparam int QUO_W    = 16;
  localparam int DIV_BITS = 2;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;

  // Inputs at or above 8.0 saturate, so only 19 bits of x reach the multipliers.
  localparam int X_W = 19;
  localparam int P_W = 37;
  localparam int T_W = 38;
  localparam int N_W = 58;
  localparam int R_W = 59;

  localparam logic [17:0] TM_A = 18'd164495;
  localparam logic [10:0] TM_B = 11'd1966;
  localparam logic [17:0] TM_C = 18'd159252;
  localparam logic [15:0] TM_D = 16'd38666;
  localparam logic [13:0] TM_E = 14'd9175;

  localparam logic [31:0] SAT_LIMIT = 32'h0008_0000;

  localparam int IDX_W   = $clog2(GAMMA_TABLE_DEPTH + 1);
  localparam int PROD_W  = QUO_W + IDX_W;

  // Pipeline depth from an accepted word to its result strobe.
  localparam int LATENCY = 3 + DIV_STAGES + 4;

  typedef struct packed {
    logic [INPUT_WIDTH-1:0] red_in;
    logic [INPUT_WIDTH-1:0] green_in;
    logic [INPUT_WIDTH-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [OUTPUT_WIDTH-1:0] red_out;
    logic [OUTPUT_WIDTH-1:0] green_out;
    logic [OUTPUT_WIDTH-1:0] blue_out;
  } pixel_out_t;

  typedef struct packed {
    logic             valid;
    logic             sat;
    logic [QUO_W-1:0] quo;
  } ratio_t;

  typedef logic [15:0] gamma_rom_t [0:GAMMA_TABLE_DEPTH];

  // Largest z with z^11 * DEPTH^5 <= k^5 * 2^176, clamped to 16 bits.
  function automatic logic [15:0] gamma_entry(int unsigned k);
    logic [255:0] rhs;
    logic [255:0] lhs;
    logic [255:0] kk;
    logic [255:0] mm;
    logic [16:0]  lo;
    logic [16:0]  hi;
    logic [16:0]  mid;
    kk  = 256'(k);
    rhs = 256'd1;
    for (int j = 0; j < 5; j++) rhs = rhs * kk;
    rhs = rhs << 176;
    lo = 17'd0;
    hi = 17'd65537;
    for (int it = 0; it < 18; it++) begin
      if (hi - lo > 17'd1) begin
        // The sum of the bounds can exceed 17 bits near the top of the range.
        mid = 17'((18'(lo) + 18'(hi)) >> 1);
        mm  = 256'(mid);
        lhs = 256'd1;
        for (int j = 0; j < 11; j++) lhs = lhs * mm;
        for (int j = 0; j < 5; j++) lhs = lhs * 256'(GAMMA_TABLE_DEPTH);
        if (lhs <= rhs) lo = mid;
        else hi = mid;
      end
    end
    return (lo > 17'd65535) ? 16'hFFFF : lo[15:0];
  endfunction

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t t;
    for (int k = 0; k <= GAMMA_TABLE_DEPTH; k++) t[k] = gamma_entry(k);
    return t;
  endfunction

endpackage

@@ design/tmg_ratio.sv @@
// One channel of the ACES rational fit: products, saturation check and a
// pipelined restoring divider producing a Q0.16 ratio. Depends on tmg_pkg.
module tmg_ratio (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [tmg_pkg::INPUT_WIDTH-1:0]  in_x,
  output tmg_pkg::ratio_t                  out_res
);

  localparam int X_W = tmg_pkg::X_W;
  localparam int P_W = tmg_pkg::P_W;
  localparam int T_W = tmg_pkg::T_W;
  localparam int N_W = tmg_pkg::N_W;
  localparam int R_W = tmg_pkg::R_W;
  localparam int Q_W = tmg_pkg::QUO_W;
  localparam int NS  = tmg_pkg::DIV_STAGES;
  localparam int PP_W = 2 * X_W;

  logic [31:0]    xw;
  logic [X_W-1:0] xs;
  logic [P_W-1:0] ax;
  logic [P_W-1:0] cx;

  logic           v1_r, big1_r;
  logic [X_W-1:0] x1_r;
  logic [P_W-1:0] ax1_r, cx1_r;

  logic [T_W-1:0]  tn, td;
  logic            v2_r, big2_r;
  logic [PP_W-1:0] numh2_r, numl2_r, denh2_r, denl2_r;
  logic [N_W-1:0]  num;
  logic [N_W-1:0]  den;

  logic           vld_r [0:NS];
  logic           sat_r [0:NS];
  logic [R_W-1:0] rem_r [0:NS];
  logic [Q_W-1:0] quo_r [0:NS];
  logic [N_W-1:0] den_r [0:NS];

  assign xw = 32'(in_x);
  assign xs = xw[X_W-1:0];
  assign ax = P_W'(tmg_pkg::TM_A) * P_W'(xs);
  assign cx = P_W'(tmg_pkg::TM_C) * P_W'(xs);

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_valid;
    big1_r <= (xw >= tmg_pkg::SAT_LIMIT);
    x1_r   <= xs;
    ax1_r  <= ax;
    cx1_r  <= cx;
  end

  assign tn = T_W'(ax1_r) + T_W'({tmg_pkg::TM_B, 16'h0000});
  assign td = T_W'(cx1_r) + T_W'({tmg_pkg::TM_D, 16'h0000});

  // The x by t products are split into two 19 by 19 halves, summed in the next stage.
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    big2_r  <= big1_r;
    numh2_r <= PP_W'(x1_r) * PP_W'(tn[T_W-1:X_W]);
    numl2_r <= PP_W'(x1_r) * PP_W'(tn[X_W-1:0]);
    denh2_r <= PP_W'(x1_r) * PP_W'(td[T_W-1:X_W]);
    denl2_r <= PP_W'(x1_r) * PP_W'(td[X_W-1:0]);
  end

  assign num = (N_W'(numh2_r) << X_W) + N_W'(numl2_r);
  assign den = (N_W'(denh2_r) << X_W) + N_W'(denl2_r)
             + N_W'({tmg_pkg::TM_E, 32'h0000_0000});

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= v2_r;
    sat_r[0] <= big2_r || (num >= den);
    rem_r[0] <= R_W'(num);
    quo_r[0] <= '0;
    den_r[0] <= den;
  end

  for (genvar s = 1; s <= NS; s++) begin : g_div
    logic [R_W-1:0] rem_nxt;
    logic [Q_W-1:0] quo_nxt;

    // Two quotient bits per stage; the remainder stays below den unless the word saturated.
    always_comb begin
      rem_nxt = rem_r[s-1];
      quo_nxt = quo_r[s-1];
      for (int b = 0; b < tmg_pkg::DIV_BITS; b++) begin
        rem_nxt = rem_nxt << 1;
        quo_nxt = quo_nxt << 1;
        if (rem_nxt >= R_W'(den_r[s-1])) begin
          rem_nxt    = rem_nxt - R_W'(den_r[s-1]);
          quo_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else vld_r[s] <= vld_r[s-1];
      sat_r[s] <= sat_r[s-1];
      rem_r[s] <= rem_nxt;
      quo_r[s] <= quo_nxt;
      den_r[s] <= den_r[s-1];
    end
  end

  assign out_res.valid = vld_r[NS];
  assign out_res.sat   = sat_r[NS];
  assign out_res.quo   = quo_r[NS];

endmodule

@@ design/tmg_gamma.sv @@
// Gamma 1/2.2 encoding of one Q0.16 ratio through an interpolated table ROM.
// Depends on tmg_pkg for the table builder and widths.
module tmg_gamma (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tmg_pkg::ratio_t                  in_res,
  output logic                             out_valid,
  output logic [tmg_pkg::OUTPUT_WIDTH-1:0] out_value
);

  localparam int IDX_W  = tmg_pkg::IDX_W;
  localparam int PROD_W = tmg_pkg::PROD_W;
  localparam int OW     = tmg_pkg::OUTPUT_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(tmg_pkg::GAMMA_TABLE_DEPTH - 1);
  localparam tmg_pkg::gamma_rom_t ROM = tmg_pkg::build_gamma();

  logic [PROD_W-1:0] p;
  logic [IDX_W-1:0]  idx;

  logic              v1_r, sat1_r;
  logic [IDX_W-1:0]  i1_r;
  logic [15:0]       f1_r;

  logic              v2_r, sat2_r;
  logic [15:0]       f2_r, lo2_r, hi2_r;

  logic [15:0]       diff;
  logic [31:0]       interp;
  logic              v3_r, sat3_r;
  logic [15:0]       lo3_r, ip3_r;

  logic [16:0]       g;
  logic [15:0]       gc;
  logic              v4_r;
  logic [OW-1:0]     out4_r;

  assign p   = PROD_W'(in_res.quo) * PROD_W'(tmg_pkg::GAMMA_TABLE_DEPTH);
  assign idx = (p[PROD_W-1:16] > LAST_IDX) ? LAST_IDX : p[PROD_W-1:16];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_res.valid;
    sat1_r <= in_res.sat;
    i1_r   <= idx;
    f1_r   <= p[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    sat2_r <= sat1_r;
    f2_r   <= f1_r;
    lo2_r  <= ROM[i1_r];
    hi2_r  <= ROM[i1_r + IDX_W'(1)];
  end

  assign diff   = (hi2_r >= lo2_r) ? (hi2_r - lo2_r) : 16'h0000;
  assign interp = 32'(diff) * 32'(f2_r) + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    sat3_r <= sat2_r;
    lo3_r  <= lo2_r;
    ip3_r  <= interp[31:16];
  end

  assign g  = 17'(lo3_r) + 17'(ip3_r);
  assign gc = g[16] ? 16'hFFFF : g[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    out4_r <= sat3_r ? '1 : gc[15 -: OW];
  end

  assign out_valid = v4_r;
  assign out_value = out4_r;

endmodule

@@ design/aces_tonemap_gamma_encode.sv @@
// ACES filmic tone mapping with gamma 1/2.2 encoding, three channels per word.
// Pipeline: 3 product stages, 8 divider stages at two quotient bits each and
// 4 table and interpolation stages lie between an accepted word and its out_strobe.
// Throughput: one word per cycle; busy is always low and nothing stalls.
// Reset: synchronous active-low rst_n clears every valid bit; data is not reset.
// Depends on tmg_pkg, tmg_ratio and tmg_gamma.
module aces_tonemap_gamma_encode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tmg_pkg::pixel_in_t  in_pixel,
  output logic                out_strobe,
  output tmg_pkg::pixel_out_t out_pixel
);

  localparam int LAT = tmg_pkg::LATENCY;

  logic            accept;
  tmg_pkg::ratio_t r_res, g_res, b_res;
  logic            r_vld, g_vld, b_vld;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  tmg_ratio u_ratio_r (.clk, .rst_n, .in_valid(accept), .in_x(in_pixel.red_in),
                       .out_res(r_res));
  tmg_ratio u_ratio_g (.clk, .rst_n, .in_valid(accept), .in_x(in_pixel.green_in),
                       .out_res(g_res));
  tmg_ratio u_ratio_b (.clk, .rst_n, .in_valid(accept), .in_x(in_pixel.blue_in),
                       .out_res(b_res));

  tmg_gamma u_gamma_r (.clk, .rst_n, .in_res(r_res), .out_valid(r_vld),
                       .out_value(out_pixel.red_out));
  tmg_gamma u_gamma_g (.clk, .rst_n, .in_res(g_res), .out_valid(g_vld),
                       .out_value(out_pixel.green_out));
  tmg_gamma u_gamma_b (.clk, .rst_n, .in_res(b_res), .out_valid(b_vld),
                       .out_value(out_pixel.blue_out));

  assign out_strobe = r_vld && g_vld && b_vld;

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (r_vld == g_vld) && (g_vld == b_vld))
    else $error("channel valid bits disagree");

  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted word");

  a_zero_in_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_pixel.red_in == '0, LAT)) |-> (out_pixel.red_out == '0))
    else $error("zero red input did not give zero output");

  a_big_in_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(32'(in_pixel.green_in) >= tmg_pkg::SAT_LIMIT, LAT))
    |-> (out_pixel.green_out == '1))
    else $error("large green input did not saturate");

endmodule
